// ===== design/quaternion_stream_normalizer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion stream normalizer
// Concurrent checks are compiled for simulation and drop out for synthesis.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_STREAM_NORMALIZER_UNIT_MACROS_SVH
`define QUATERNION_STREAM_NORMALIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QSN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QSN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QSN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define QSN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/qsn_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsn_pkg
// Shared widths, step counts and the lane control bundle.
// ---------------------------------------------------------------------------
package qsn_pkg;

  localparam int FRAC_BITS_DEF  = 20;
  localparam int COMP_WIDTH_DEF = 24;

  localparam int THR_W     = 23;
  localparam int THR_RESET = 1;
  localparam int OUT_W     = 22;
  localparam int N_COMP    = 4;

  // the largest normalized magnitude sits in [2^29, 2^30]
  localparam int NORM_LO_BIT = 29;
  localparam int NORM_HI_BIT = 30;
  localparam int NM_W        = 31;
  localparam int SQ_W        = 2 * NM_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int RREM_W      = ROOT_W + 2;
  localparam int DREM_W      = ROOT_W + 1;

  localparam int SQ_STEPS   = NM_W;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic load;
    logic shl;
    logic shr;
    logic sq_init;
    logic sq_step;
    logic dv_init;
    logic dv_step;
  } qsn_lane_ctrl_t;

endpackage

// ===== design/qsn_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qsn_lane
// One component lane: magnitude shifter, bit-serial squarer and a
// bit-serial restoring divider that yields the rounded unit magnitude.
// ---------------------------------------------------------------------------
module qsn_lane import qsn_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int MAG_W     = (COMP_WIDTH > NM_W) ? COMP_WIDTH : NM_W
) (
  input  logic                 clk_i,
  input  qsn_lane_ctrl_t       ctrl_i,
  input  logic [MAG_W-1:0]     mag_i,
  input  logic [ROOT_W-1:0]    root_i,
  output logic [MAG_W-1:0]     mag_o,
  output logic [SQ_W-1:0]      sq_o,
  output logic [FRAC_BITS:0]   quo_o
);

  localparam int NUM_W = NM_W + FRAC_BITS;

  logic [MAG_W-1:0]   mag_q, mag_d;
  logic [SQ_W-1:0]    mcand_q, mcand_d;
  logic [NM_W-1:0]    mplier_q, mplier_d;
  logic [SQ_W-1:0]    acc_q, acc_d;
  logic [DREM_W-1:0]  rem_q, rem_d;
  logic [FRAC_BITS:0] lo_q, lo_d;

  logic [NUM_W-1:0]   num;
  logic [DREM_W-1:0]  trial;
  logic               qbit;

  always_comb begin
    num   = {mag_q[NM_W-1:0], {FRAC_BITS{1'b0}}} + NUM_W'(root_i >> 1);
    trial = {rem_q[DREM_W-2:0], lo_q[FRAC_BITS]};
    qbit  = (trial >= {1'b0, root_i});
  end

  always_comb begin
    mag_d    = mag_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    lo_d     = lo_q;
    if (ctrl_i.load) begin
      mag_d = mag_i;
    end else if (ctrl_i.shl) begin
      mag_d = mag_q << 1;
    end else if (ctrl_i.shr) begin
      mag_d = mag_q >> 1;
    end
    if (ctrl_i.sq_init) begin
      mcand_d  = SQ_W'(mag_q[NM_W-1:0]);
      mplier_d = mag_q[NM_W-1:0];
      acc_d    = '0;
    end else if (ctrl_i.sq_step) begin
      // add the shifted multiplicand for each set multiplier bit
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
    end
    if (ctrl_i.dv_init) begin
      // quotient has FRAC_BITS+1 bits, so the upper part starts below root_i
      rem_d = DREM_W'(num >> (FRAC_BITS + 1));
      lo_d  = num[FRAC_BITS:0];
    end else if (ctrl_i.dv_step) begin
      rem_d = qbit ? (trial - {1'b0, root_i}) : trial;
      lo_d  = {lo_q[FRAC_BITS-1:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    lo_q     <= lo_d;
  end

  assign mag_o = mag_q;
  assign sq_o  = acc_q;
  assign quo_o = lo_q;

endmodule

// ===== design/quaternion_stream_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_stream_normalizer_unit
// Scales each incoming quaternion to unit length, or repeats the held unit
// quaternion when every component is below the zero threshold or all are zero.
// ---------------------------------------------------------------------------
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     tdata: comp x,y,z,w; tuser: first_point
// m_axis    out  m_axis_tvalid/tready     tdata: unit x,y,z,w; tuser: held
// cfg       in   cfg_we_i                 cfg_wdata_i: zero_threshold
//
// An empty item goes from accept straight to the done state. A normalized
// item passes the normalizing shifts, the bit-serial squarers (31 steps),
// two adds, the two-bit-per-cycle root (32 steps) and the bit-serial
// dividers (FRAC_BITS+1 steps). Reset loads the identity, no sweep.
// A finished result waits in its stage until the output register is free;
// the output register itself holds while m_axis_tready is low.
// ---------------------------------------------------------------------------
`include "quaternion_stream_normalizer_unit_macros.svh"

module quaternion_stream_normalizer_unit import qsn_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  localparam int IN_DATA_W = ((N_COMP * COMP_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((N_COMP * OUT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [THR_W-1:0]      cfg_wdata_i,   // zero_threshold
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
  input  logic                  s_axis_tuser,  // first_point
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // unit_x, unit_y, unit_z, unit_w
  output logic                  m_axis_tuser   // held
);

  localparam int MAG_W = (COMP_WIDTH > NM_W) ? COMP_WIDTH : NM_W;
  localparam logic [63:0] IDENT64 = 64'd1 << FRAC_BITS;
  localparam logic [COMP_WIDTH-1:0] IDENT_W = IDENT64[COMP_WIDTH-1:0];
  localparam logic [MAG_W-1:0] NORM_HI = MAG_W'(64'd1 << NORM_HI_BIT);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_NORM  = 4'd1;
  localparam logic [3:0] ST_SQR   = 4'd2;
  localparam logic [3:0] ST_ADD1  = 4'd3;
  localparam logic [3:0] ST_ADD2  = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_DPREP = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [THR_W-1:0] thr_q;
  logic             out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic             out_held_q;

  logic [N_COMP-1:0][COMP_WIDTH-1:0] last_unit_q;
  logic [N_COMP-1:0][COMP_WIDTH-1:0] unit_next;
  logic [N_COMP-1:0]                 neg_q;
  logic                              held_q;

  logic [SUM_W-1:0]  p0_q, p1_q;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [RREM_W-1:0] rrem_q, rrem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  qsn_lane_ctrl_t    lane_ctrl;
  logic [N_COMP-1:0][MAG_W-1:0]   in_mag;
  logic [N_COMP-1:0][MAG_W-1:0]   lane_mag;
  logic [N_COMP-1:0][SQ_W-1:0]    lane_sq;
  logic [N_COMP-1:0][FRAC_BITS:0] lane_quo;
  logic [N_COMP-1:0]              in_neg;

  logic in_acc, out_free, load_out, in_empty;
  logic shl_need, shr_need;
  logic [RREM_W+1:0] rt_r, rt_t;
  logic [OUT_DATA_W-1:0] out_data_d;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // magnitudes and the empty test on the incoming request
  always_comb begin
    logic [COMP_WIDTH-1:0] v;
    logic [COMP_WIDTH-1:0] mag_c;
    logic any_big;
    logic any_set;
    any_big = 1'b0;
    any_set = 1'b0;
    for (int i = 0; i < N_COMP; i++) begin
      v         = s_axis_tdata[i*COMP_WIDTH +: COMP_WIDTH];
      in_neg[i] = v[COMP_WIDTH-1];
      mag_c     = in_neg[i] ? ((~v) + COMP_WIDTH'(1)) : v;
      in_mag[i] = MAG_W'(mag_c);
      if (in_mag[i] >= MAG_W'(thr_q)) begin
        any_big = 1'b1;
      end
      if (in_mag[i] != '0) begin
        any_set = 1'b1;
      end
    end
    in_empty = !any_big || !any_set;
  end

  // normalizing direction from the lane magnitudes
  always_comb begin
    logic [MAG_W-1:0] mag_or;
    mag_or   = '0;
    shr_need = 1'b0;
    for (int i = 0; i < N_COMP; i++) begin
      mag_or = mag_or | lane_mag[i];
      if (lane_mag[i] > NORM_HI) begin
        shr_need = 1'b1;
      end
    end
    shl_need = ~|mag_or[MAG_W-1:NORM_LO_BIT];
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lane_ctrl = '0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lane_ctrl.load = 1'b1;
          state_d = in_empty ? ST_DONE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (shl_need) begin
          lane_ctrl.shl = 1'b1;
        end else if (shr_need) begin
          lane_ctrl.shr = 1'b1;
        end else begin
          lane_ctrl.sq_init = 1'b1;
          cnt_d   = '0;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        lane_ctrl.sq_step = 1'b1;
        if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_ADD1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ADD1: begin
        state_d = ST_ADD2;
      end
      ST_ADD2: begin
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DPREP;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DPREP: begin
        lane_ctrl.dv_init = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.dv_step = 1'b1;
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // digit-by-digit square root, two radicand bits per step
  always_comb begin
    rad_d  = rad_q;
    rrem_d = rrem_q;
    root_d = root_q;
    rt_r   = {rrem_q, rad_q[RAD_W-1 -: 2]};
    rt_t   = {2'b00, root_q, 2'b01};
    if (state_q == ST_ADD2) begin
      rad_d  = {1'b0, p0_q + p1_q};
      rrem_d = '0;
      root_d = '0;
    end else if (state_q == ST_ROOT) begin
      rad_d = rad_q << 2;
      if (rt_r >= rt_t) begin
        rrem_d = RREM_W'(rt_r - rt_t);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rrem_d = rt_r[RREM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result selection: held value or signed quotient
  always_comb begin
    logic [63:0] qx;
    logic [63:0] sv;
    logic [63:0] ux;
    out_data_d = '0;
    for (int i = 0; i < N_COMP; i++) begin
      qx = 64'(lane_quo[i]);
      sv = neg_q[i] ? (64'd0 - qx) : qx;
      unit_next[i] = held_q ? last_unit_q[i] : sv[COMP_WIDTH-1:0];
      ux = 64'(unit_next[i]);
      out_data_d[i*OUT_W +: OUT_W] = ux[OUT_W-1:0];
    end
  end

  for (genvar g = 0; g < N_COMP; g++) begin : g_lane
    qsn_lane #(
      .COMP_WIDTH (COMP_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .mag_i  (in_mag[g]),
      .root_i (root_q),
      .mag_o  (lane_mag[g]),
      .sq_o   (lane_sq[g]),
      .quo_o  (lane_quo[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      thr_q       <= THR_W'(THR_RESET);
      out_valid_q <= 1'b0;
      for (int i = 0; i < N_COMP; i++) begin
        last_unit_q[i] <= (i == N_COMP - 1) ? IDENT_W : '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // restart the trajectory before this request is processed
      if (in_acc && s_axis_tuser) begin
        for (int i = 0; i < N_COMP; i++) begin
          last_unit_q[i] <= (i == N_COMP - 1) ? IDENT_W : '0;
        end
      end else if (load_out) begin
        last_unit_q <= unit_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rrem_q <= rrem_d;
    root_q <= root_d;
    if (in_acc) begin
      neg_q  <= in_neg;
      held_q <= in_empty;
    end
    if (state_q == ST_ADD1) begin
      p0_q <= SUM_W'(lane_sq[0]) + SUM_W'(lane_sq[1]);
      p1_q <= SUM_W'(lane_sq[2]) + SUM_W'(lane_sq[3]);
    end
    if (load_out) begin
      out_data_q <= out_data_d;
      out_held_q <= held_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_held_q;

  `QSN_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, state_q != ST_IDLE,
                  "sequencer stayed idle after a request")
  `QSN_ASSERT_IMP(a_norm_settled, clk_i, rst_ni, state_q == ST_SQR,
                  !shl_need && !shr_need, "magnitudes left normal range while squaring")
  `QSN_ASSERT_IMP(a_root_count, clk_i, rst_ni, state_q == ST_ROOT,
                  cnt_q < CNT_W'(ROOT_STEPS), "root step count overran")
  `QSN_ASSERT_NXT(a_held_keeps_unit, clk_i, rst_ni, load_out && held_q,
                  $stable(last_unit_q), "held result changed the stored unit quaternion")

endmodule
